### hdl/cvfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvfd_pkg
// Shared types, constants and the PEC update for the cell-voltage frame decoder.
// ----------------------------------------------------------------------------
package cvfd_pkg;

    localparam int FRAME_DATA_BYTES_DEF = 18;
    localparam int CELLS_PER_PACK_DEF   = 3;
    localparam int CODE_OFFSET_DEF      = 512;

    localparam logic [7:0] PEC_SEED = 8'h41;
    localparam logic [7:0] PEC_POLY = 8'h07;

    localparam logic [3:0]  CELLS_IN_USE_RST = 4'd6;
    localparam logic [11:0] LOW_CODE_RST     = 12'd2846;
    localparam logic [11:0] SHUTDOWN_CODE_RST = 12'd2579;

    localparam int CFG_DATA_W = 12;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_CELLS_IN_USE  = 2'd0,
        REG_LOW_CODE      = 2'd1,
        REG_SHUTDOWN_CODE = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_CELL = 1'b0,
        KIND_EOF  = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        STATUS_NORMAL   = 2'd0,
        STATUS_LOW      = 2'd1,
        STATUS_SHUTDOWN = 2'd2
    } cell_status_t;

    typedef struct packed {
        logic [3:0]  cells_in_use;
        logic [11:0] low_code_below;
        logic [11:0] shutdown_code_below;
    } cvfd_cfg_t;

    // One classified word handed from the front end to the back end
    typedef struct packed {
        item_kind_t  kind;
        logic [3:0]  cell_index;
        logic [11:0] code;
        logic        pec_ok;
        logic        pack_clear;
    } cvfd_item_t;

    // CRC-8, x^8+x^2+x+1, MSB first, one byte per call
    function automatic logic [7:0] pec_update(logic [7:0] pec, logic [7:0] b);
        logic [7:0] p;
        logic       fb;
        p = pec;
        for (int i = 7; i >= 0; i--) begin
            fb = b[i] ^ p[7];
            p  = {p[6:0], 1'b0} ^ (fb ? PEC_POLY : 8'h00);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

### hdl/cvfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvfd_front
// Accepts frame bytes, tracks position and PEC, unpacks 12-bit cell codes.
// ----------------------------------------------------------------------------
module cvfd_front #(
    parameter int FRAME_DATA_BYTES = cvfd_pkg::FRAME_DATA_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_rx_byte,
    input  wire logic                  s_frame_start,
    input  wire logic [3:0]            cells_in_use,
    input  wire logic                  q_full,
    output logic                       q_push,
    output cvfd_pkg::cvfd_item_t       q_item
);
    import cvfd_pkg::*;

    localparam int POS_W     = $clog2(FRAME_DATA_BYTES + 2);
    localparam int NUM_CELLS = 2 * ((FRAME_DATA_BYTES + 2) / 3);
    localparam int CELL_W0   = $clog2(NUM_CELLS + 1);
    localparam int CELL_W    = (CELL_W0 > 4) ? CELL_W0 : 4;

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]        pec_reg, pec_next, pec_eff;
    logic [7:0]        held_reg, held_next;
    logic [1:0]        phase_reg, phase_next, phase_eff;
    logic [CELL_W-1:0] base_reg, base_next, base_eff;
    logic              clr_pend_reg, clr_pend_next;

    logic              accept;
    logic [CELL_W-1:0] cell_sel;
    logic [11:0]       code;
    logic              emit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign pos_eff   = s_frame_start ? '0 : pos_reg;
    assign pec_eff   = s_frame_start ? PEC_SEED : pec_reg;
    assign phase_eff = s_frame_start ? 2'd0 : phase_reg;
    assign base_eff  = s_frame_start ? '0 : base_reg;

    always_comb begin
        pos_next   = pos_reg;
        pec_next   = pec_reg;
        held_next  = held_reg;
        phase_next = phase_reg;
        base_next  = base_reg;
        q_push     = 1'b0;
        q_item     = '0;
        cell_sel   = base_eff;
        code       = {s_rx_byte[3:0], held_reg};
        emit       = 1'b0;
        if (phase_eff == 2'd2) begin
            cell_sel = base_eff + CELL_W'(1);
            code     = {s_rx_byte, held_reg[7:4]};
        end
        if (accept) begin
            pos_next   = pos_eff;
            pec_next   = pec_eff;
            phase_next = phase_eff;
            base_next  = base_eff;
            if (pos_eff == POS_W'(FRAME_DATA_BYTES)) begin
                // PEC byte closes the frame
                pos_next         = POS_W'(FRAME_DATA_BYTES + 1);
                q_push           = 1'b1;
                q_item.kind      = KIND_EOF;
                q_item.pec_ok    = (s_rx_byte == pec_eff);
            end else if (pos_eff < POS_W'(FRAME_DATA_BYTES)) begin
                pos_next  = pos_eff + POS_W'(1);
                pec_next  = pec_update(pec_eff, s_rx_byte);
                held_next = s_rx_byte;
                unique case (phase_eff)
                    2'd0: begin
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        phase_next = 2'd2;
                        emit       = 1'b1;
                    end
                    default: begin
                        phase_next = 2'd0;
                        base_next  = base_eff + CELL_W'(2);
                        emit       = 1'b1;
                    end
                endcase
                if (emit && (cell_sel < CELL_W'(cells_in_use))) begin
                    q_push            = 1'b1;
                    q_item.kind       = KIND_CELL;
                    q_item.cell_index = cell_sel[3:0];
                    q_item.code       = code;
                end
            end
            q_item.pack_clear = clr_pend_reg || s_frame_start;
        end
    end

    // carry a frame start forward until a word is pushed into the queue
    always_comb begin
        clr_pend_next = clr_pend_reg;
        if (q_push) begin
            clr_pend_next = 1'b0;
        end else if (accept && s_frame_start) begin
            clr_pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            pec_reg      <= PEC_SEED;
            phase_reg    <= 2'd0;
            base_reg     <= '0;
            clr_pend_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            pec_reg      <= pec_next;
            phase_reg    <= phase_next;
            base_reg     <= base_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule
`default_nettype wire

### hdl/cvfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvfd_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module cvfd_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  cvfd_pkg::cvfd_item_t   push_item,
    output logic                   full,
    output logic                   q_valid,
    input  wire logic              pop,
    output cvfd_pkg::cvfd_item_t   pop_item
);
    import cvfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cvfd_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hdl/cvfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvfd_back
// Converts cell codes to volts, classifies status, sums packs, holds results.
// ----------------------------------------------------------------------------
module cvfd_back #(
    parameter int CELLS_PER_PACK = cvfd_pkg::CELLS_PER_PACK_DEF,
    parameter int CODE_OFFSET    = cvfd_pkg::CODE_OFFSET_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    pop,
    input  cvfd_pkg::cvfd_item_t    item,
    input  wire logic [11:0]        low_code_below,
    input  wire logic [11:0]        shutdown_code_below,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic [3:0]              m_cell_index,
    output logic signed [12:0]      m_cell_volts,
    output logic [1:0]              m_cell_status,
    output logic                    m_pack_done,
    output logic signed [14:0]      m_pack_sum,
    output logic                    m_pec_ok
);
    import cvfd_pkg::*;

    localparam int CNT_W = $clog2(CELLS_PER_PACK + 1);
    localparam logic signed [15:0] SUM_MAX = 16'sd16383;
    localparam logic signed [15:0] SUM_MIN = -16'sd16384;
    localparam logic [12:0] OFFSET = 13'(CODE_OFFSET);

    logic signed [14:0] acc_reg, acc_next, acc_base;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_base, cnt_inc;
    logic               valid_reg, valid_next;

    logic               kind_reg, kind_next;
    logic [3:0]         idx_reg, idx_next;
    logic signed [12:0] volts_reg, volts_next;
    cell_status_t       status_reg, status_next;
    logic               done_reg, done_next;
    logic signed [14:0] sum_reg, sum_next;
    logic               pec_reg, pec_next;

    logic signed [12:0] volts;
    logic signed [15:0] sum_wide;
    logic signed [14:0] sum_sat;
    cell_status_t       status;

    assign pop = q_valid && (!valid_reg || m_ready);

    assign acc_base = item.pack_clear ? '0 : acc_reg;
    assign cnt_base = item.pack_clear ? '0 : cnt_reg;
    assign cnt_inc  = cnt_base + CNT_W'(1);
    assign volts    = $signed({1'b0, item.code} - OFFSET);
    assign sum_wide = 16'(acc_base) + 16'(volts);

    always_comb begin
        priority if (sum_wide > SUM_MAX) begin
            sum_sat = SUM_MAX[14:0];
        end else if (sum_wide < SUM_MIN) begin
            sum_sat = SUM_MIN[14:0];
        end else begin
            sum_sat = sum_wide[14:0];
        end
    end

    // shutdown wins over low
    always_comb begin
        priority if (item.code < shutdown_code_below) begin
            status = STATUS_SHUTDOWN;
        end else if (item.code < low_code_below) begin
            status = STATUS_LOW;
        end else begin
            status = STATUS_NORMAL;
        end
    end

    always_comb begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        volts_next  = volts_reg;
        status_next = status_reg;
        done_next   = done_reg;
        sum_next    = sum_reg;
        pec_next    = pec_reg;
        valid_next  = valid_reg && !m_ready;
        if (pop) begin
            valid_next  = 1'b1;
            acc_next    = acc_base;
            cnt_next    = cnt_base;
            kind_next   = item.kind;
            idx_next    = '0;
            volts_next  = '0;
            status_next = STATUS_NORMAL;
            done_next   = 1'b0;
            sum_next    = '0;
            pec_next    = 1'b0;
            unique case (item.kind)
                KIND_EOF: begin
                    pec_next = item.pec_ok;
                end
                default: begin
                    idx_next    = item.cell_index;
                    volts_next  = volts;
                    status_next = status;
                    if (cnt_inc >= CNT_W'(CELLS_PER_PACK)) begin
                        done_next = 1'b1;
                        sum_next  = sum_sat;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end else begin
                        acc_next = sum_sat;
                        cnt_next = cnt_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        volts_reg  <= volts_next;
        status_reg <= status_next;
        done_reg   <= done_next;
        sum_reg    <= sum_next;
        pec_reg    <= pec_next;
    end

    assign m_valid       = valid_reg;
    assign m_kind        = kind_reg;
    assign m_cell_index  = idx_reg;
    assign m_cell_volts  = volts_reg;
    assign m_cell_status = status_reg;
    assign m_pack_done   = done_reg;
    assign m_pack_sum    = sum_reg;
    assign m_pec_ok      = pec_reg;

endmodule
`default_nettype wire

### hdl/cell_voltage_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_voltage_frame_decoder
// Checks the PEC of a cell-voltage frame and unpacks, classifies and sums cells.
// ----------------------------------------------------------------------------
//   channel  direction  word
//   s_       in         one frame byte plus frame-start mark
//   m_       out        one cell result or one end-of-frame result
//   cfg_     in         register write, index and data, no handshake
//
// One byte is accepted per cycle while the queue has room; a result is registered
// in the two-entry queue and then in the output register. The queue fills only when
// m_ready stays low, and s_ready drops once it is full. Reset is synchronous
// and clears position, PEC seed, pack sum and all handshake state.
// ----------------------------------------------------------------------------
module cell_voltage_frame_decoder #(
    parameter int FRAME_DATA_BYTES = cvfd_pkg::FRAME_DATA_BYTES_DEF,
    parameter int CELLS_PER_PACK   = cvfd_pkg::CELLS_PER_PACK_DEF,
    parameter int CODE_OFFSET      = cvfd_pkg::CODE_OFFSET_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [cvfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_rx_byte,
    input  wire logic                          s_frame_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [3:0]                         m_cell_index,
    output logic signed [12:0]                 m_cell_volts,
    output logic [1:0]                         m_cell_status,
    output logic                               m_pack_done,
    output logic signed [14:0]                 m_pack_sum,
    output logic                               m_pec_ok
);
    import cvfd_pkg::*;

    cvfd_cfg_t  cfg_reg, cfg_next;
    cvfd_item_t push_item, pop_item;
    logic       q_push, q_full, q_valid, q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CELLS_IN_USE:  cfg_next.cells_in_use        = cfg_wdata[3:0];
                REG_LOW_CODE:      cfg_next.low_code_below      = cfg_wdata[11:0];
                REG_SHUTDOWN_CODE: cfg_next.shutdown_code_below = cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cells_in_use        <= CELLS_IN_USE_RST;
            cfg_reg.low_code_below      <= LOW_CODE_RST;
            cfg_reg.shutdown_code_below <= SHUTDOWN_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cvfd_front #(
        .FRAME_DATA_BYTES (FRAME_DATA_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_frame_start (s_frame_start),
        .cells_in_use  (cfg_reg.cells_in_use),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    cvfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    cvfd_back #(
        .CELLS_PER_PACK (CELLS_PER_PACK),
        .CODE_OFFSET    (CODE_OFFSET)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .pop                 (q_pop),
        .item                (pop_item),
        .low_code_below      (cfg_reg.low_code_below),
        .shutdown_code_below (cfg_reg.shutdown_code_below),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_cell_index        (m_cell_index),
        .m_cell_volts        (m_cell_volts),
        .m_cell_status       (m_cell_status),
        .m_pack_done         (m_pack_done),
        .m_pack_sum          (m_pack_sum),
        .m_pec_ok            (m_pec_ok)
    );

    a_eof_fields_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind) |-> (m_cell_volts == 13'sd0 && m_pack_done == 1'b0
                                 && m_pack_sum == 15'sd0 && m_cell_index == 4'd0))
        else $error("end-of-frame word carries cell fields");

    a_sum_only_on_done : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pack_done) |-> (m_pack_sum == 15'sd0))
        else $error("pack sum without pack done");

    a_cell_in_use : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_kind) |-> (m_cell_index < cfg_reg.cells_in_use && !m_pec_ok))
        else $error("cell result for a cell not in use");

    a_pop_needs_room : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && m_valid) |-> m_ready)
        else $error("output word overwritten while stalled");

endmodule
`default_nettype wire
